// File: sv/jqe_pkg.sv
package jqe_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_TABLES    = 2;
  localparam int POS_W         = $clog2(TABLE_ENTRIES);

  localparam int QVAL_W   = 16;
  localparam int STD_W    = 7;
  localparam int SCORE_W  = 17;
  localparam int SUM_W    = 24;
  localparam int COUNT_W  = 8;
  localparam int QUAL_W   = 7;
  localparam int DVD_W    = 22;
  localparam int DVS_W    = 16;
  localparam int DCNT_W   = $clog2(DVD_W + 1);
  localparam int NUM_W    = 31;

  localparam logic [SCORE_W-1:0] SCORE_ONE   = 17'd65536;
  localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [QUAL_W-1:0]  QUALITY_MAX = 7'd100;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_ONE,
    MODE_GT,
    MODE_LE
  } mode_e;

  typedef struct packed {
    logic [QVAL_W-1:0] qval;
    logic [STD_W-1:0]  std_val;
    mode_e             mode;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DVD_W-1:0]  quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_QMUL,
    ST_QDIV,
    ST_OUT
  } state_e;

  localparam logic [STD_W-1:0] STD_LUMA [TABLE_ENTRIES] = '{
    7'd16, 7'd11, 7'd10, 7'd16, 7'd24,  7'd40,  7'd51,  7'd61,
    7'd12, 7'd12, 7'd14, 7'd19, 7'd26,  7'd58,  7'd60,  7'd55,
    7'd14, 7'd13, 7'd16, 7'd24, 7'd40,  7'd57,  7'd69,  7'd56,
    7'd14, 7'd17, 7'd22, 7'd29, 7'd51,  7'd87,  7'd80,  7'd62,
    7'd18, 7'd22, 7'd37, 7'd56, 7'd68,  7'd109, 7'd103, 7'd77,
    7'd24, 7'd35, 7'd55, 7'd64, 7'd81,  7'd104, 7'd113, 7'd92,
    7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
    7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
  };

  localparam logic [STD_W-1:0] STD_CHROMA [TABLE_ENTRIES] = '{
    7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
  };

  // chroma falls back to luma when only one table is built in
  function automatic logic [STD_W-1:0] std_entry(input logic tid,
                                                 input logic [POS_W-1:0] pos);
    logic [STD_W-1:0] val;
    if (tid && (MAX_TABLES > 1)) val = STD_CHROMA[pos];
    else                         val = STD_LUMA[pos];
    return val;
  endfunction

endpackage

// File: sv/jqe_front.sv
module jqe_front import jqe_pkg::*; (
  input  logic [QVAL_W-1:0] quant_value_i,
  input  logic              table_id_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic              last_i,
  output cmd_t              cmd_o
);

  logic [STD_W-1:0] std_val;

  always_comb begin
    std_val       = std_entry(table_id_i, position_i);
    cmd_o.qval    = quant_value_i;
    cmd_o.std_val = std_val;
    cmd_o.last    = last_i;
    // value one is full quality, larger than standard divides the other way
    if (quant_value_i == QVAL_W'(1))                    cmd_o.mode = MODE_ONE;
    else if (quant_value_i > QVAL_W'(std_val))          cmd_o.mode = MODE_GT;
    else                                                cmd_o.mode = MODE_LE;
  end

endmodule

// File: sv/jqe_cmd_queue.sv
module jqe_cmd_queue import jqe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t cmd_i,
  input  logic rd_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd)      cnt_d = cnt_q + 1'b1;
    else if (!do_wr && do_rd) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: sv/jqe_divider.sv
module jqe_divider import jqe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  // restoring division, one quotient bit a cycle
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_sub;
  logic              fits;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = DCNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], fits};
      rem_d = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_no_zero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.divisor != '0)
    else $error("divider started with zero divisor");

endmodule

// File: sv/jqe_back.sv
module jqe_back import jqe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_rd_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [QUAL_W-1:0] quality_o
);

  state_e             state_q, state_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [SCORE_W-1:0] score_q, score_d;
  logic               gt_q, gt_d;
  logic               last_q, last_d;
  logic [QUAL_W-1:0]  qual_q, qual_d;
  logic               out_valid_q, out_valid_d;
  logic [QUAL_W-1:0]  out_qual_q, out_qual_d;
  logic [SUM_W:0]     sum_ext;
  logic [NUM_W-1:0]   num;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  jqe_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign empty_o   = !out_valid_q;
  assign quality_o = out_qual_q;

  always_comb begin
    state_d          = state_q;
    sum_d            = sum_q;
    count_d          = count_q;
    score_d          = score_q;
    gt_d             = gt_q;
    last_d           = last_q;
    qual_d           = qual_q;
    out_valid_d      = out_valid_q;
    out_qual_d       = out_qual_q;
    cmd_rd_o         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {cmd_i.std_val, 15'b0};
    div_req.divisor  = cmd_i.qval;
    sum_ext          = {1'b0, sum_q} + (SUM_W + 1)'(score_q);
    num              = NUM_W'(sum_q) * NUM_W'(QUALITY_MAX)
                     + NUM_W'({count_q, 15'b0});

    if (pop_i && out_valid_q) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_rd_o = 1'b1;
          last_d   = cmd_i.last;
          gt_d     = (cmd_i.mode == MODE_GT);
          unique case (cmd_i.mode)
            MODE_ONE: begin
              score_d = SCORE_ONE;
              state_d = ST_ACC;
            end
            MODE_GT: begin
              div_req.start = 1'b1;
              state_d       = ST_DIV;
            end
            default: begin
              // value is at most the standard entry, so it fits its width
              div_req.start    = 1'b1;
              div_req.dividend = {cmd_i.qval[STD_W-1:0], 15'b0};
              div_req.divisor  = DVS_W'(cmd_i.std_val);
              state_d          = ST_DIV;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          score_d = gt_q ? div_rsp.quotient[SCORE_W-1:0]
                         : SCORE_ONE - div_rsp.quotient[SCORE_W-1:0];
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        sum_d = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        if (count_q != COUNT_MAX) count_d = count_q + 1'b1;
        state_d = last_q ? ST_QMUL : ST_IDLE;
      end
      ST_QMUL: begin
        // divide by count*65536 as drop of low half, then divide by count
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(num[NUM_W-1:16]);
        div_req.divisor  = DVS_W'(count_q);
        state_d          = ST_QDIV;
      end
      ST_QDIV: begin
        if (div_rsp.done) begin
          qual_d  = (div_rsp.quotient > DVD_W'(QUALITY_MAX))
                    ? QUALITY_MAX : div_rsp.quotient[QUAL_W-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_qual_d  = qual_q;
          sum_d       = '0;
          count_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q    <= score_d;
    gt_q       <= gt_d;
    last_q     <= last_d;
    qual_q     <= qual_d;
    out_qual_q <= out_qual_d;
  end

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_QMUL |-> count_q != '0)
    else $error("quality divide with zero entry count");

  a_quality_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_qual_q <= QUALITY_MAX)
    else $error("quality above 100");

  a_start_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (state_q == ST_IDLE || state_q == ST_QMUL))
    else $error("divider started from wrong state");

  a_sum_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |=> sum_q >= $past(sum_q))
    else $error("score sum decreased on accumulate");

endmodule

// File: sv/jpeg_quality_estimator.sv
// jpeg quality estimator: push quantization table entries, one word each
// (value, luma/chroma table, position, last flag); each entry is scored
// against the standard table entry at its position and summed, and the
// entry marked last yields one quality word (0..100, mean score times 100
// rounded half up), after which the sum and count clear. a front stage looks
// up the standard entry and classifies the word into a two-entry command
// queue; the back stage scores it with a serial restoring divider that
// produces one quotient bit per cycle. the back stage dequeues an entry,
// divides and accumulates it; an entry of value one skips the divider. the
// last entry adds a final divide by the entry count. full stays low while
// the queue has room, and the single result word waits on the output while
// work continues
module jpeg_quality_estimator import jqe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input word
  input  logic              push,
  output logic              full,
  input  logic [QVAL_W-1:0] quant_value_i,
  input  logic              table_id_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic              last_i,
  // result word
  output logic              empty,
  input  logic              pop,
  output logic [QUAL_W-1:0] quality_o
);

  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_empty;
  logic cmd_rd;

  // lookup and classification
  jqe_front u_front (
    .quant_value_i (quant_value_i),
    .table_id_i    (table_id_i),
    .position_i    (position_i),
    .last_i        (last_i),
    .cmd_o         (cmd_in)
  );

  // short queue decouples input side from the divider
  jqe_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .cmd_i   (cmd_in),
    .rd_i    (cmd_rd),
    .cmd_o   (cmd_out),
    .full_o  (full),
    .empty_o (cmd_empty)
  );

  // scoring, accumulation and final quality
  jqe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_rd_o    (cmd_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .quality_o   (quality_o)
  );

endmodule
